// File: hw/rtl/aes128_pkg.sv
// AES-128 types, S-box and round helper functions.
package aes128_pkg;

  typedef logic [127:0] block_t;

  localparam int unsigned NumRounds = 10;

  // configuration register indexes
  localparam logic KeyLowIdx  = 1'b0;
  localparam logic KeyHighIdx = 1'b1;

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes + ShiftRows; byte i sits at bits 8i+7:8i, row i%4, column i/4
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[32*c +: 8]    = a0 ^ all ^ xtime(a0 ^ a1);
      t[32*c+8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
      t[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

  // one key expansion step from the previous round key
  function automatic block_t next_key(input block_t p, input logic [7:0] rc);
    block_t n;
    logic [31:0] t;
    t = {SBOX[p[103:96]], SBOX[p[127:120]], SBOX[p[119:112]], SBOX[p[111:104]] ^ rc};
    n[31:0]   = p[31:0] ^ t;
    n[63:32]  = p[63:32] ^ n[31:0];
    n[95:64]  = p[95:64] ^ n[63:32];
    n[127:96] = p[127:96] ^ n[95:64];
    next_key = n;
  endfunction

endpackage

// File: hw/rtl/aes128_block_encrypt_core.sv
// AES-128 encryption core: unrolled ten-round pipeline with on-the-fly key schedule.
// One block enters per cycle while out_ready is held high; each block passes through the
// initial AddRoundKey stage and one register stage per round before it leaves. The key
// schedule runs alongside the data, one expansion step per round stage, so each block
// carries the key that was set when it was taken. Each stage loads when it is empty or
// its content moves on to the next stage, so bubbles are squeezed out; in_ready follows
// out_ready combinationally when the pipeline is full.
// Config index 0 writes key_low, index 1 key_high.
module aes128_block_encrypt_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] plain_low,
  input  logic [63:0] plain_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] cipher_low,
  output logic [63:0] cipher_high
);

  localparam int unsigned Stages = aes128_pkg::NumRounds + 1;

  logic [127:0] key;
  aes128_pkg::block_t st [Stages];
  aes128_pkg::block_t rk [Stages-1];
  logic [Stages-1:0] vld;
  logic [Stages-1:0] adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      if (cfg_index == aes128_pkg::KeyLowIdx) key[63:0] <= cfg_data;
      else key[127:64] <= cfg_data;
    end
  end

  // stage i may load when it is empty or its own content moves on
  always_comb begin
    adv[Stages-1] = !vld[Stages-1] || out_ready;
    for (int i = Stages - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < Stages; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st[0] <= {plain_high, plain_low} ^ key;
      rk[0] <= key;
    end
    for (int i = 1; i < Stages; i++) begin
      if (adv[i]) begin
        if (i < Stages - 1) begin
          rk[i] <= aes128_pkg::next_key(rk[i-1], aes128_pkg::RCON[i-1]);
        end
        if (i == Stages - 1) begin
          st[i] <= aes128_pkg::sub_shift(st[i-1])
                   ^ aes128_pkg::next_key(rk[i-1], aes128_pkg::RCON[i-1]);
        end else begin
          st[i] <= aes128_pkg::mix_columns(aes128_pkg::sub_shift(st[i-1]))
                   ^ aes128_pkg::next_key(rk[i-1], aes128_pkg::RCON[i-1]);
        end
      end
    end
  end

  assign out_valid   = vld[Stages-1];
  assign cipher_low  = st[Stages-1][63:0];
  assign cipher_high = st[Stages-1][127:64];

endmodule

// File: bench/aes128_block_encrypt_core_chk.sv
// Checker for the AES-128 core: tracks key writes, predicts ciphertext, compares outputs.
module aes128_block_encrypt_core_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] plain_low,
  input  logic [63:0] plain_high,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] cipher_low,
  input  logic [63:0] cipher_high,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] key_lo_q, key_hi_q;
  aes128_pkg::block_t cipher_q[$];

  function automatic logic [7:0] gf_dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte-array AES-128, memory order byte i = bits 8i+7:8i
  function automatic aes128_pkg::block_t encrypt(input aes128_pkg::block_t key,
                                                 input aes128_pkg::block_t pt);
    logic [7:0] rk[11][16];
    logic [7:0] s[16], t[16], w[4];
    logic [7:0] a0, a1, a2, a3, x;
    aes128_pkg::block_t res;
    for (int i = 0; i < 16; i++) begin
      rk[0][i] = key[8*i +: 8];
      s[i] = pt[8*i +: 8];
    end
    for (int r = 1; r <= 10; r++) begin
      w[0] = aes128_pkg::SBOX[rk[r-1][13]] ^ aes128_pkg::RCON[r-1];
      w[1] = aes128_pkg::SBOX[rk[r-1][14]];
      w[2] = aes128_pkg::SBOX[rk[r-1][15]];
      w[3] = aes128_pkg::SBOX[rk[r-1][12]];
      for (int i = 0; i < 4; i++) rk[r][i] = rk[r-1][i] ^ w[i];
      for (int i = 4; i < 16; i++) rk[r][i] = rk[r-1][i] ^ rk[r][i-4];
    end
    for (int i = 0; i < 16; i++) s[i] ^= rk[0][i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++) t[q+4*c] = aes128_pkg::SBOX[s[q+4*((c+q)%4)]];
      s = t;
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ x ^ gf_dbl(a0 ^ a1);
          s[4*c+1] = a1 ^ x ^ gf_dbl(a1 ^ a2);
          s[4*c+2] = a2 ^ x ^ gf_dbl(a2 ^ a3);
          s[4*c+3] = a3 ^ x ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[r][i];
    end
    for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
    return res;
  endfunction

  assign pending = cipher_q.size();

  always @(posedge clk) begin
    aes128_pkg::block_t want;
    int errs;
    errs = 0;
    if (rst) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
      cipher_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        cipher_q.push_back(encrypt({key_hi_q, key_lo_q}, {plain_high, plain_low}));
      if (cfg_we) begin
        if (cfg_index == aes128_pkg::KeyLowIdx) key_lo_q <= cfg_data;
        else if (cfg_index == aes128_pkg::KeyHighIdx) key_hi_q <= cfg_data;
      end
      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected result %h_%h", $time, cipher_high, cipher_low);
          errs++;
        end else begin
          want = cipher_q.pop_front();
          if (cipher_low !== want[63:0]) begin
            $display("%0t: cipher_low expected %h actual %h", $time, want[63:0], cipher_low);
            errs++;
          end
          if (cipher_high !== want[127:64]) begin
            $display("%0t: cipher_high expected %h actual %h", $time, want[127:64],
                     cipher_high);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

// File: bench/aes128_block_encrypt_core_tb.sv
// Top of the AES-128 core bench: clock, reset, key phases, block stimulus, verdict.
module aes128_block_encrypt_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 40;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = aes128_pkg::KeyLowIdx;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [63:0] plain_low = '0, plain_high = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] cipher_low, cipher_high;
  int fail_count, pending;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  always #5 clk = ~clk;

  aes128_block_encrypt_core u_dut (.*);

  aes128_block_encrypt_core_chk u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 30);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // receiver: random stalls, calm stretches, and one long hold-off on request
  initial begin : sink
    int n;
    while (1) begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      n = $urandom_range(0, 9);
      if (n < 6 || stim_done) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [63:0] lo, input logic [63:0] hi, input bit gaps);
    int g;
    in_valid <= 1'b1;
    plain_low <= lo;
    plain_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_key(input logic idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // the first edge lets the checker take in the last transfer before the count is read
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    logic [63:0] klo, khi;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // zero key first, then the FIPS-197 appendix vector
    send('0, '0, 0);
    send('1, '1, 0);
    send(64'h7766554433221100, 64'hffeeddccbbaa9988, 0);
    quiesce();
    write_key(aes128_pkg::KeyLowIdx, 64'h0706050403020100);
    write_key(aes128_pkg::KeyHighIdx, 64'h0f0e0d0c0b0a0908);
    send(64'h7766554433221100, 64'hffeeddccbbaa9988, 0);
    send('0, '1, 0);
    send('1, '0, 0);
    for (int b = 0; b < 8; b++) send(64'h1 << (b * 8), 64'h80 << (b * 8), 0);
    quiesce();
    write_key(aes128_pkg::KeyLowIdx, '1);
    write_key(aes128_pkg::KeyHighIdx, '1);
    send('0, '0, 0);
    send('1, '1, 0);
    send(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0);
    // long receiver stall with the sender still pushing
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) send(rnd64(), rnd64(), 0);
    for (int p = 0; p < 7; p++) begin
      quiesce();
      case (p % 3)
        0: begin klo = rnd64(); khi = rnd64(); end
        1: begin klo = '0; khi = rnd64(); end
        default: begin klo = rnd64(); khi = '1; end
      endcase
      write_key(aes128_pkg::KeyLowIdx, klo);
      write_key(aes128_pkg::KeyHighIdx, khi);
      for (int i = 0; i < 240; i++) send(rnd64(), rnd64(), (i % 80) >= 30);
    end
    quiesce();
    stim_done = 1'b1;
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
